/* sv/level_set_upwind_update_macros.svh */
// assertion helpers shared by the level set update block
`ifndef LEVEL_SET_UPWIND_UPDATE_MACROS_SVH
`define LEVEL_SET_UPWIND_UPDATE_MACROS_SVH

// implication checked on every clock edge outside reset
`define LSU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition that must never be seen outside reset
`define LSU_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

/* sv/lsu_pkg.sv */
// ----------------------------------------------------------------------------
// lsu_pkg
// Types, register indexes and shared arithmetic helpers of the level set
// upwind update block.
// ----------------------------------------------------------------------------
package lsu_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_TIME_STEP = 2'd0;
  localparam logic [1:0] REG_INV_DX_SQ = 2'd1;
  localparam logic [1:0] REG_INV_DY_SQ = 2'd2;

  localparam logic [63:0] SAT64 = {64{1'b1}};

  // input word
  typedef struct packed {
    logic signed [31:0] center_value;
    logic signed [31:0] west_value;
    logic signed [31:0] east_value;
    logic signed [31:0] south_value;
    logic signed [31:0] north_value;
    logic signed [31:0] speed;
    logic               on_barrier;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [31:0] new_value;
    logic               barrier_crossed;
  } out_word_t;

  // data that rides alongside the gradient and root pipeline
  typedef struct packed {
    logic signed [31:0] center;
    logic               sp_pos;
    logic               barrier;
    logic [63:0]        ts;
  } side_t;

  // saturating 64-bit unsigned add
  function automatic logic [63:0] add_sat64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? SAT64 : s[63:0];
  endfunction

  // join (x*y)>>frac from the partial products of x's halves, saturated
  function automatic logic [63:0] join_shift_sat(input logic [63:0] hi,
                                                 input logic [63:0] lo,
                                                 input int unsigned frac);
    logic [63:0] a;
    logic [63:0] b;
    logic [64:0] s;
    a = hi << (32 - frac);
    b = lo >> frac;
    s = {1'b0, a} + {1'b0, b};
    if ((hi >> (32 + frac)) != 64'd0 || s[64])
      return SAT64;
    return s[63:0];
  endfunction

  // upwind magnitude of a 33-bit difference
  function automatic logic [31:0] pos_mag(input logic signed [32:0] d);
    return (!d[32] && d != 33'sd0) ? d[31:0] : 32'd0;
  endfunction

endpackage

/* sv/lsu_grad.sv */
// ----------------------------------------------------------------------------
// lsu_grad
// Six-stage pipeline from a grid point to the weighted squared gradient
// norm, with the time step times speed product carried alongside.
// ----------------------------------------------------------------------------
module lsu_grad import lsu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  in_word_t    item,
  input  logic [31:0] time_step,
  input  logic [31:0] inv_dx_sq,
  input  logic [31:0] inv_dy_sq,
  output logic        out_valid,
  output logic [63:0] total,
  output side_t       side
);

  logic [5:0]  vld;
  logic [31:0] mw, me, ms, mn;
  logic [31:0] abs_sp;
  side_t       side0, side1, side2, side3, side4, side5;
  logic [63:0] sq_w, sq_e, sq_s, sq_n;
  logic [63:0] sum_x, sum_y;
  logic [63:0] px_lo, px_hi, py_lo, py_hi;
  logic [63:0] term_x, term_y;
  logic [63:0] total_q;

  logic signed [32:0] c33, w33, e33, s33, n33;
  logic               sp_pos;
  logic [63:0]        ts_prod;

  assign c33    = {item.center_value[31], item.center_value};
  assign w33    = {item.west_value[31], item.west_value};
  assign e33    = {item.east_value[31], item.east_value};
  assign s33    = {item.south_value[31], item.south_value};
  assign n33    = {item.north_value[31], item.north_value};
  assign sp_pos = item.speed > 32'sd0;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], in_valid};
    end
  end

  // stage 0: upwind one-sided differences
  always_ff @(posedge clk) begin
    if (sp_pos) begin
      mw <= pos_mag(c33 - w33);
      me <= pos_mag(c33 - e33);
      ms <= pos_mag(c33 - s33);
      mn <= pos_mag(c33 - n33);
    end else begin
      mw <= pos_mag(w33 - c33);
      me <= pos_mag(e33 - c33);
      ms <= pos_mag(s33 - c33);
      mn <= pos_mag(n33 - c33);
    end
    abs_sp <= item.speed[31] ? 32'(-item.speed) : item.speed;
    side0  <= '{center: item.center_value, sp_pos: sp_pos,
                barrier: item.on_barrier, ts: '0};
  end

  // stage 1: squares and time step times speed
  assign ts_prod = 64'(time_step) * 64'(abs_sp);

  always_ff @(posedge clk) begin
    sq_w  <= 64'(mw) * 64'(mw);
    sq_e  <= 64'(me) * 64'(me);
    sq_s  <= 64'(ms) * 64'(ms);
    sq_n  <= 64'(mn) * 64'(mn);
    side1 <= '{center: side0.center, sp_pos: side0.sp_pos,
               barrier: side0.barrier, ts: ts_prod >> FRAC_BITS};
  end

  // stage 2: per-axis sums
  always_ff @(posedge clk) begin
    sum_x <= add_sat64(sq_w, sq_e);
    sum_y <= add_sat64(sq_s, sq_n);
    side2 <= side1;
  end

  // stage 3: partial products of the axis weighting
  always_ff @(posedge clk) begin
    px_lo <= 64'(sum_x[31:0]) * 64'(inv_dx_sq);
    px_hi <= 64'(sum_x[63:32]) * 64'(inv_dx_sq);
    py_lo <= 64'(sum_y[31:0]) * 64'(inv_dy_sq);
    py_hi <= 64'(sum_y[63:32]) * 64'(inv_dy_sq);
    side3 <= side2;
  end

  // stage 4: weighted axis terms
  always_ff @(posedge clk) begin
    term_x <= join_shift_sat(px_hi, px_lo, FRAC_BITS);
    term_y <= join_shift_sat(py_hi, py_lo, FRAC_BITS);
    side4  <= side3;
  end

  // stage 5: squared norm
  always_ff @(posedge clk) begin
    total_q <= add_sat64(term_x, term_y);
    side5   <= side4;
  end

  assign out_valid = vld[5];
  assign total     = total_q;
  assign side      = side5;

endmodule

/* sv/lsu_sqrt.sv */
// ----------------------------------------------------------------------------
// lsu_sqrt
// Pipelined integer square root of a 64-bit value, one result bit per
// stage over 32 stages, with side data carried along.
// ----------------------------------------------------------------------------
module lsu_sqrt import lsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [63:0] radicand,
  input  side_t       in_side,
  output logic        out_valid,
  output logic [31:0] root,
  output side_t       out_side
);

  localparam int STAGES = 32;

  logic        vld   [0:STAGES-1];
  logic [63:0] rem_q [0:STAGES-1];
  logic [63:0] res_q [0:STAGES-1];
  side_t       sd_q  [0:STAGES-1];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int SH = 62 - 2 * s;
    logic        vld_in;
    logic [63:0] rem_in, res_in, trial;
    side_t       sd_in;

    if (s == 0) begin : g_first
      assign vld_in = in_valid;
      assign rem_in = radicand;
      assign res_in = '0;
      assign sd_in  = in_side;
    end else begin : g_rest
      assign vld_in = vld[s-1];
      assign rem_in = rem_q[s-1];
      assign res_in = res_q[s-1];
      assign sd_in  = sd_q[s-1];
    end

    assign trial = res_in + (64'd1 << SH);

    // valid bit
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= vld_in;
      end
    end

    // one root bit
    always_ff @(posedge clk) begin
      if (rem_in >= trial) begin
        rem_q[s] <= rem_in - trial;
        res_q[s] <= (res_in >> 1) + (64'd1 << SH);
      end else begin
        rem_q[s] <= rem_in;
        res_q[s] <= res_in >> 1;
      end
      sd_q[s] <= sd_in;
    end
  end

  assign out_valid = vld[STAGES-1];
  assign root      = res_q[STAGES-1][31:0];
  assign out_side  = sd_q[STAGES-1];

endmodule

/* sv/level_set_upwind_update.sv */
// done and the result word are registered together by the final update stage.
// Throughput: one word per cycle; busy stays low, nothing stalls.
// The depth is set by the 32-stage square root between the gradient
// pipeline (six stages) and the step multiply, join and update stages.
// Reset clears all valid bits and sets time_step to 0, both inverse
// squared spacings to 1.0.
// ----------------------------------------------------------------------------
// level_set_upwind_update
// First-order upwind explicit Euler update of a level set value at one
// grid point, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
`include "level_set_upwind_update_macros.svh"

module level_set_upwind_update import lsu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_word_t    item,
  output logic        done,
  output out_word_t   result,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int LAT = 41;
  localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

  logic [31:0] time_step, inv_dx_sq, inv_dy_sq;
  logic        g_valid, r_valid;
  logic [63:0] g_total;
  side_t       g_side, r_side, p_side, q_side;
  logic [31:0] norm;
  logic        p_valid, q_valid;
  logic [63:0] p_lo, p_hi, step;
  logic        done_q;
  out_word_t   result_q;

  logic signed [35:0] c36, nv36;
  logic signed [31:0] nv;

  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= '0;
      inv_dx_sq <= ONE;
      inv_dy_sq <= ONE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TIME_STEP: time_step <= cfg_data;
        REG_INV_DX_SQ: inv_dx_sq <= cfg_data;
        REG_INV_DY_SQ: inv_dy_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  lsu_grad #(.FRAC_BITS(FRAC_BITS)) u_grad (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .item      (item),
    .time_step (time_step),
    .inv_dx_sq (inv_dx_sq),
    .inv_dy_sq (inv_dy_sq),
    .out_valid (g_valid),
    .total     (g_total),
    .side      (g_side)
  );

  lsu_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_valid),
    .radicand  (g_total),
    .in_side   (g_side),
    .out_valid (r_valid),
    .root      (norm),
    .out_side  (r_side)
  );

  // valid bits of the step and update stages
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      q_valid <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      p_valid <= r_valid;
      q_valid <= p_valid;
      done_q  <= q_valid;
    end
  end

  // step partial products
  always_ff @(posedge clk) begin
    p_lo   <= 64'(r_side.ts[31:0]) * 64'(norm);
    p_hi   <= 64'(r_side.ts[63:32]) * 64'(norm);
    p_side <= r_side;
  end

  // step magnitude
  always_ff @(posedge clk) begin
    step   <= join_shift_sat(p_hi, p_lo, FRAC_BITS);
    q_side <= p_side;
  end

  // apply the step and saturate
  assign c36 = 36'(q_side.center);

  always_comb begin
    nv36 = q_side.sp_pos ? c36 - $signed({2'b00, step[33:0]})
                         : c36 + $signed({2'b00, step[33:0]});
    if (step > (64'd1 << 33)) begin
      nv = q_side.sp_pos ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (nv36 > 36'sh0_7FFF_FFFF) begin
      nv = 32'sh7FFF_FFFF;
    end else if (nv36 < -36'sh0_8000_0000) begin
      nv = 32'sh8000_0000;
    end else begin
      nv = nv36[31:0];
    end
  end

  always_ff @(posedge clk) begin
    result_q <= '{new_value: nv, barrier_crossed: q_side.barrier &&
      ((q_side.center < 0 && nv > 0) || (q_side.center > 0 && nv < 0))};
  end

  assign done   = done_q;
  assign result = result_q;

  // checks
  `LSU_ASSERT_IMP(a_done_from_start, done, $past(start, LAT), "result without a word")
  `LSU_ASSERT_IMP(a_cross_needs_barrier, done && result.barrier_crossed,
    $past(item.on_barrier, LAT), "crossing flagged off the barrier")
  `LSU_ASSERT_IMP(a_zero_speed_pass, done && $past(item.speed, LAT) == 32'sd0,
    result.new_value == $past(item.center_value, LAT), "zero speed changed value")
  `LSU_ASSERT_NEVER(a_cross_nonzero, done && result.barrier_crossed &&
    result.new_value == 32'sd0, "crossing flagged at zero")

endmodule
